@@ rtl/core/gsdc_pkg.sv @@
// ----------------------------------------------------------------------------
// gsdc_pkg: shared types and constants of the stick conditioner
// Field widths, register indexes and the request/response structs that pass
// between the top level, the stick engine and the shared arithmetic unit.
// ----------------------------------------------------------------------------
package gsdc_pkg;

  // Field widths
  localparam int AXIS_W = 16;
  localparam int BTN_W  = 17;
  localparam int DZ_W   = 15;

  // Shared unit widths
  localparam int MUL_W  = 17;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SUB_W  = 28;

  // Iteration counts: root of a 48-bit radicand, 17 quotient bits
  localparam int SQRT_STEPS = 24;
  localparam int DIV_STEPS  = 17;
  localparam int CNT_W      = 5;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_DZ  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_DZ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANALOG   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP     = 2'd3;

  // Operands for the shared multiply / compare-subtract unit
  typedef struct packed {
    logic [MUL_W-1:0] mul_a;
    logic [MUL_W-1:0] mul_b;
    logic [SUB_W-1:0] sub_a;
    logic [SUB_W-1:0] sub_b;
  } alu_req_t;

  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic [SUB_W-1:0]  diff;
    logic              ge;
  } alu_rsp_t;

  // One stick to condition
  typedef struct packed {
    logic                     start;
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic [DZ_W-1:0]          dz;
  } stk_req_t;

  // Conditioned stick, valid for one cycle with done
  typedef struct packed {
    logic                     done;
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
  } stk_rsp_t;

endpackage

@@ rtl/core/gsdc_poll_if.sv @@
// ----------------------------------------------------------------------------
// gsdc_poll_if: controller poll channel
// One request per poll: pad-present bit, two raw stick pairs, button mask.
// ----------------------------------------------------------------------------
interface gsdc_poll_if;
  logic                             valid;
  logic                             ready;
  logic                             pad_present;
  logic signed [gsdc_pkg::AXIS_W-1:0] raw_left_x;
  logic signed [gsdc_pkg::AXIS_W-1:0] raw_left_y;
  logic signed [gsdc_pkg::AXIS_W-1:0] raw_right_x;
  logic signed [gsdc_pkg::AXIS_W-1:0] raw_right_y;
  logic [gsdc_pkg::BTN_W-1:0]         button_mask;

  modport source (
    output valid, pad_present, raw_left_x, raw_left_y, raw_right_x, raw_right_y,
    output button_mask,
    input  ready
  );

  modport sink (
    input  valid, pad_present, raw_left_x, raw_left_y, raw_right_x, raw_right_y,
    input  button_mask,
    output ready
  );
endinterface

@@ rtl/core/gsdc_result_if.sv @@
// ----------------------------------------------------------------------------
// gsdc_result_if: conditioned stick channel
// One request per poll: four conditioned axes, button mask, activity flag.
// ----------------------------------------------------------------------------
interface gsdc_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [gsdc_pkg::AXIS_W-1:0] left_x_out;
  logic signed [gsdc_pkg::AXIS_W-1:0] left_y_out;
  logic signed [gsdc_pkg::AXIS_W-1:0] right_x_out;
  logic signed [gsdc_pkg::AXIS_W-1:0] right_y_out;
  logic [gsdc_pkg::BTN_W-1:0]         buttons_out;
  logic                             activity;

  modport source (
    output valid, left_x_out, left_y_out, right_x_out, right_y_out,
    output buttons_out, activity,
    input  ready
  );

  modport sink (
    input  valid, left_x_out, left_y_out, right_x_out, right_y_out,
    input  buttons_out, activity,
    output ready
  );
endinterface

@@ rtl/core/gamepad_stick_deadzone_curve.sv @@
// ----------------------------------------------------------------------------
// gamepad_stick_deadzone_curve: stick deadzone and response curve conditioner
// Takes one controller poll, conditions both sticks and reports activity.
// ----------------------------------------------------------------------------
// Usage
//   poll_i carries one request per poll: pad-present bit, the raw left and
//   right stick pairs and the button mask. result_o returns one request per
//   poll with the four conditioned axes, the buttons and the activity flag.
//   Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i: left and
//   right deadzone, analog mode, stick swap. The user must write them only
//   while the block is idle; the block itself does not enforce this.
// Sequencing
//   poll_i.ready is high only while the sequencer is idle; one poll at a
//   time. In analog mode with a pad present each stick runs through one
//   shared multiplier and subtractor, and the root and quotient steps take
//   most of that work. A stick that stays in its deadzone leaves the stick
//   engine early. Digital mode, and a poll with no pad, skip the engine.
// Reset and stall
//   Reset clears the deadzones, selects analog mode, clears swap and the
//   previous buttons. A result waits in the output register while result_o
//   is stalled; the next poll is still taken and worked on, then held with
//   poll_i.ready low until the output register frees.
// ----------------------------------------------------------------------------
module gamepad_stick_deadzone_curve #(
  parameter int unsigned AXIS_MAX = 32767
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  gsdc_poll_if.sink                         poll_i,
  gsdc_result_if.source                     result_o,
  input  logic                              cfg_we_i,
  input  logic [gsdc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gsdc_pkg::DZ_W-1:0]         cfg_data_i
);

  localparam logic [gsdc_pkg::DZ_W-1:0]   AMAX   = gsdc_pkg::DZ_W'(AXIS_MAX);
  localparam logic [gsdc_pkg::AXIS_W-1:0] AMAX_P = {1'b0, AMAX};

  typedef enum logic [2:0] {
    ST_IDLE, ST_LEFT, ST_RIGHT, ST_DIG, ST_OUT
  } state_e;

  state_e                              state_q;
  logic [gsdc_pkg::DZ_W-1:0]           left_dz_q, right_dz_q;
  logic                                analog_q, swap_q;
  logic signed [gsdc_pkg::AXIS_W-1:0]  lx_q, ly_q, rx_q, ry_q;
  logic signed [gsdc_pkg::AXIS_W-1:0]  olx_q, oly_q, orx_q, ory_q;
  logic [gsdc_pkg::BTN_W-1:0]          btn_q, prev_btn_q;
  logic                                start_q;
  logic                                out_valid_q;
  logic signed [gsdc_pkg::AXIS_W-1:0]  res_lx_q, res_ly_q, res_rx_q, res_ry_q;
  logic [gsdc_pkg::BTN_W-1:0]          res_btn_q;
  logic                                res_act_q;

  logic                                poll_fire;
  logic                                out_free;
  logic                                out_load;
  logic                                start_d;
  logic                                activity;
  gsdc_pkg::stk_req_t                  stk_req;
  gsdc_pkg::stk_rsp_t                  stk_rsp;

  // Digital axis: full scale in the direction of travel past the deadzone
  function automatic logic [gsdc_pkg::AXIS_W-1:0] dig_axis(
    logic signed [gsdc_pkg::AXIS_W-1:0] x, logic [gsdc_pkg::DZ_W-1:0] dz);
    logic [gsdc_pkg::AXIS_W:0] a;
    a = x[gsdc_pkg::AXIS_W-1] ? (gsdc_pkg::AXIS_W+1)'(-{x[gsdc_pkg::AXIS_W-1], x})
                              : {1'b0, x};
    if (a > {2'b00, dz}) begin
      return x[gsdc_pkg::AXIS_W-1] ? gsdc_pkg::AXIS_W'(-AMAX_P) : AMAX_P;
    end
    return '0;
  endfunction

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_dz_q  <= '0;
      right_dz_q <= '0;
      analog_q   <= 1'b1;
      swap_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gsdc_pkg::CFG_LEFT_DZ:  left_dz_q  <= cfg_data_i;
        gsdc_pkg::CFG_RIGHT_DZ: right_dz_q <= cfg_data_i;
        gsdc_pkg::CFG_ANALOG:   analog_q   <= cfg_data_i[0];
        gsdc_pkg::CFG_SWAP:     swap_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign poll_i.ready = (state_q == ST_IDLE);
  assign poll_fire    = poll_i.valid && poll_i.ready;
  assign out_free     = !out_valid_q || result_o.ready;
  assign out_load     = (state_q == ST_OUT) && out_free;
  assign activity     = (olx_q != '0) || (oly_q != '0) || (orx_q != '0) ||
                        (ory_q != '0) || (btn_q != prev_btn_q);

  // Start the stick engine on an analog poll, then again for the right stick
  assign start_d = (poll_fire && poll_i.pad_present && analog_q) ||
                   ((state_q == ST_LEFT) && stk_rsp.done);

  // Feed the stick engine with the pair being worked on
  assign stk_req.start = start_q;
  assign stk_req.x     = (state_q == ST_RIGHT) ? rx_q : lx_q;
  assign stk_req.y     = (state_q == ST_RIGHT) ? ry_q : ly_q;
  assign stk_req.dz    = (state_q == ST_RIGHT) ? right_dz_q : left_dz_q;

  gsdc_stick #(
    .AXIS_MAX (AXIS_MAX)
  ) u_stick (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (stk_req),
    .rsp_o  (stk_rsp)
  );

  // Poll sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lx_q        <= '0;
      ly_q        <= '0;
      rx_q        <= '0;
      ry_q        <= '0;
      olx_q       <= '0;
      oly_q       <= '0;
      orx_q       <= '0;
      ory_q       <= '0;
      btn_q       <= '0;
      prev_btn_q  <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      res_lx_q    <= '0;
      res_ly_q    <= '0;
      res_rx_q    <= '0;
      res_ry_q    <= '0;
      res_btn_q   <= '0;
      res_act_q   <= 1'b0;
    end else begin
      start_q <= start_d;
      // Raise valid on a hand-over, drop it once the request is taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (poll_fire) begin
            // Latch the pairs, exchanged if asked; deadzones stay in place
            lx_q  <= swap_q ? poll_i.raw_right_x : poll_i.raw_left_x;
            ly_q  <= swap_q ? poll_i.raw_right_y : poll_i.raw_left_y;
            rx_q  <= swap_q ? poll_i.raw_left_x  : poll_i.raw_right_x;
            ry_q  <= swap_q ? poll_i.raw_left_y  : poll_i.raw_right_y;
            btn_q <= poll_i.pad_present ? poll_i.button_mask : '0;
            olx_q <= '0;
            oly_q <= '0;
            orx_q <= '0;
            ory_q <= '0;
            if (!poll_i.pad_present) begin
              state_q <= ST_OUT;
            end else if (analog_q) begin
              state_q <= ST_LEFT;
            end else begin
              state_q <= ST_DIG;
            end
          end
        end
        ST_LEFT: begin
          if (stk_rsp.done) begin
            olx_q   <= stk_rsp.x;
            oly_q   <= stk_rsp.y;
            state_q <= ST_RIGHT;
          end
        end
        ST_RIGHT: begin
          if (stk_rsp.done) begin
            orx_q   <= stk_rsp.x;
            ory_q   <= stk_rsp.y;
            state_q <= ST_OUT;
          end
        end
        ST_DIG: begin
          olx_q   <= dig_axis(lx_q, left_dz_q);
          oly_q   <= dig_axis(ly_q, left_dz_q);
          orx_q   <= dig_axis(rx_q, right_dz_q);
          ory_q   <= dig_axis(ry_q, right_dz_q);
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          // Hold until the output register is free, then hand over
          if (out_load) begin
            res_lx_q    <= olx_q;
            res_ly_q    <= oly_q;
            res_rx_q    <= orx_q;
            res_ry_q    <= ory_q;
            res_btn_q   <= btn_q;
            res_act_q   <= activity;
            prev_btn_q  <= btn_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.left_x_out  = res_lx_q;
  assign result_o.left_y_out  = res_ly_q;
  assign result_o.right_x_out = res_rx_q;
  assign result_o.right_y_out = res_ry_q;
  assign result_o.buttons_out = res_btn_q;
  assign result_o.activity    = res_act_q;

endmodule

@@ rtl/core/gsdc_alu.sv @@
// ----------------------------------------------------------------------------
// gsdc_alu: shared arithmetic unit
// A 17x17 unsigned multiplier and a 28-bit compare-subtract, shared by all
// steps of the stick engine (squares, root digits, quotient digits, scaling).
// ----------------------------------------------------------------------------
module gsdc_alu (
  input  gsdc_pkg::alu_req_t req_i,
  output gsdc_pkg::alu_rsp_t rsp_o
);

  // Multiply, product is registered by the caller
  assign rsp_o.prod = {{gsdc_pkg::MUL_W{1'b0}}, req_i.mul_a} *
                      {{gsdc_pkg::MUL_W{1'b0}}, req_i.mul_b};

  // Trial subtract with its borrow-free flag
  assign rsp_o.diff = req_i.sub_a - req_i.sub_b;
  assign rsp_o.ge   = (req_i.sub_a >= req_i.sub_b);

endmodule

@@ rtl/core/gsdc_stick.sv @@
// ----------------------------------------------------------------------------
// gsdc_stick: analog stick engine
// Sequences the shared unit through one stick: squared radius, deadzone test,
// digit-by-digit square root, restoring division, square of the ratio and
// scaling of both axes. Done pulses for one cycle with the result.
// ----------------------------------------------------------------------------
module gsdc_stick #(
  parameter int unsigned AXIS_MAX = 32767
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gsdc_pkg::stk_req_t req_i,
  output gsdc_pkg::stk_rsp_t rsp_o
);

  localparam int MAG_W = gsdc_pkg::DZ_W + 8;
  localparam logic [gsdc_pkg::DZ_W-1:0] AMAX    = gsdc_pkg::DZ_W'(AXIS_MAX);
  localparam logic [MAG_W-1:0]          MAG_MAX = {AMAX, 8'd0};

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_DZ, ST_SQRT, ST_NORM, ST_DIV, ST_MSQ,
    ST_SCX, ST_SCY, ST_FIN
  } state_e;

  state_e                        state_q;
  logic                          neg_x_q, neg_y_q;
  logic [gsdc_pkg::AXIS_W-1:0]   ax_q, ay_q;
  logic [gsdc_pkg::DZ_W-1:0]     dz_q, den_q;
  logic [31:0]                   s_q;
  logic [47:0]                   v_q;
  logic [gsdc_pkg::SUB_W-1:0]    rem_q;
  logic [23:0]                   root_q;
  logic [gsdc_pkg::DIV_STEPS-1:0] nb_q;
  logic [gsdc_pkg::MUL_W-1:0]    m_q, m2_q, magx_q, magy_q;
  logic [gsdc_pkg::CNT_W-1:0]    cnt_q;
  logic                          done_q;
  logic signed [gsdc_pkg::AXIS_W-1:0] ox_q, oy_q;

  gsdc_pkg::alu_req_t alu_req;
  gsdc_pkg::alu_rsp_t alu_rsp;

  logic [MAG_W-1:0] mag_clamped, dz_scaled, mag_excess;
  logic             dz_skip, norm_skip, done_d;

  gsdc_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Saturate a magnitude to the axis range and restore its sign
  function automatic logic [gsdc_pkg::AXIS_W-1:0] to_axis(
    logic [gsdc_pkg::MUL_W-1:0] mag, logic neg);
    logic [gsdc_pkg::DZ_W-1:0] sat;
    sat = (mag > {2'b00, AMAX}) ? AMAX : mag[gsdc_pkg::DZ_W-1:0];
    return neg ? gsdc_pkg::AXIS_W'(-{1'b0, sat}) : {1'b0, sat};
  endfunction

  // Clamp the root to full scale and take off the deadzone
  assign mag_clamped = (root_q > {1'b0, MAG_MAX}) ? MAG_MAX : root_q[MAG_W-1:0];
  assign dz_scaled   = {dz_q, 8'd0};
  assign mag_excess  = mag_clamped - dz_scaled;

  // Early exits to zero, and the one-cycle done pulse
  assign dz_skip   = (dz_q >= AMAX) || (s_q <= alu_rsp.prod[31:0]);
  assign norm_skip = (mag_clamped <= dz_scaled);
  assign done_d    = ((state_q == ST_DZ) && dz_skip) ||
                     ((state_q == ST_NORM) && norm_skip) ||
                     (state_q == ST_FIN);

  // Steer operands into the shared unit
  always_comb begin
    alu_req = '0;
    case (state_q)
      ST_SQX: begin
        alu_req.mul_a = {1'b0, ax_q};
        alu_req.mul_b = {1'b0, ax_q};
      end
      ST_SQY: begin
        alu_req.mul_a = {1'b0, ay_q};
        alu_req.mul_b = {1'b0, ay_q};
      end
      ST_DZ: begin
        alu_req.mul_a = {2'b00, dz_q};
        alu_req.mul_b = {2'b00, dz_q};
      end
      ST_SQRT: begin
        alu_req.sub_a = {rem_q[gsdc_pkg::SUB_W-3:0], v_q[47:46]};
        alu_req.sub_b = {2'b00, root_q, 2'b01};
      end
      ST_DIV: begin
        alu_req.sub_a = {rem_q[gsdc_pkg::SUB_W-2:0], nb_q[gsdc_pkg::DIV_STEPS-1]};
        alu_req.sub_b = {{(gsdc_pkg::SUB_W - gsdc_pkg::DZ_W){1'b0}}, den_q};
      end
      ST_MSQ: begin
        alu_req.mul_a = m_q;
        alu_req.mul_b = m_q;
      end
      ST_SCX: begin
        alu_req.mul_a = {1'b0, ax_q};
        alu_req.mul_b = m2_q;
      end
      ST_SCY: begin
        alu_req.mul_a = {1'b0, ay_q};
        alu_req.mul_b = m2_q;
      end
      default: alu_req = '0;
    endcase
  end

  // Sequencer and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      neg_x_q <= 1'b0;
      neg_y_q <= 1'b0;
      ax_q    <= '0;
      ay_q    <= '0;
      dz_q    <= '0;
      den_q   <= '0;
      s_q     <= '0;
      v_q     <= '0;
      rem_q   <= '0;
      root_q  <= '0;
      nb_q    <= '0;
      m_q     <= '0;
      m2_q    <= '0;
      magx_q  <= '0;
      magy_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      ox_q    <= '0;
      oy_q    <= '0;
    end else begin
      done_q <= done_d;
      case (state_q)
        ST_IDLE: begin
          if (req_i.start) begin
            neg_x_q <= req_i.x[gsdc_pkg::AXIS_W-1];
            neg_y_q <= req_i.y[gsdc_pkg::AXIS_W-1];
            ax_q    <= req_i.x[gsdc_pkg::AXIS_W-1] ?
                       gsdc_pkg::AXIS_W'(-req_i.x) : req_i.x;
            ay_q    <= req_i.y[gsdc_pkg::AXIS_W-1] ?
                       gsdc_pkg::AXIS_W'(-req_i.y) : req_i.y;
            dz_q    <= req_i.dz;
            state_q <= ST_SQX;
          end
        end
        ST_SQX: begin
          s_q     <= alu_rsp.prod[31:0];
          state_q <= ST_SQY;
        end
        ST_SQY: begin
          s_q     <= s_q + alu_rsp.prod[31:0];
          state_q <= ST_DZ;
        end
        ST_DZ: begin
          // Inside the deadzone, or deadzone at full scale: drop to zero
          if (dz_skip) begin
            ox_q    <= '0;
            oy_q    <= '0;
            state_q <= ST_IDLE;
          end else begin
            v_q     <= {s_q, 16'd0};
            rem_q   <= '0;
            root_q  <= '0;
            cnt_q   <= gsdc_pkg::CNT_W'(gsdc_pkg::SQRT_STEPS - 1);
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          // One root bit per cycle
          v_q <= {v_q[45:0], 2'b00};
          if (alu_rsp.ge) begin
            rem_q  <= alu_rsp.diff;
            root_q <= {root_q[22:0], 1'b1};
          end else begin
            rem_q  <= alu_req.sub_a;
            root_q <= {root_q[22:0], 1'b0};
          end
          if (cnt_q == '0) begin
            state_q <= ST_NORM;
          end else begin
            cnt_q <= cnt_q - gsdc_pkg::CNT_W'(1);
          end
        end
        ST_NORM: begin
          if (norm_skip) begin
            ox_q    <= '0;
            oy_q    <= '0;
            state_q <= ST_IDLE;
          end else begin
            // Dividend is excess << 8, divisor is full scale less deadzone
            rem_q   <= gsdc_pkg::SUB_W'(mag_excess[MAG_W-1:9]);
            nb_q    <= {mag_excess[8:0], 8'd0};
            den_q   <= AMAX - dz_q;
            m_q     <= '0;
            cnt_q   <= gsdc_pkg::CNT_W'(gsdc_pkg::DIV_STEPS - 1);
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          // One quotient bit per cycle
          nb_q <= {nb_q[gsdc_pkg::DIV_STEPS-2:0], 1'b0};
          rem_q <= alu_rsp.ge ? alu_rsp.diff : alu_req.sub_a;
          m_q   <= {m_q[gsdc_pkg::MUL_W-2:0], alu_rsp.ge};
          if (cnt_q == '0) begin
            state_q <= ST_MSQ;
          end else begin
            cnt_q <= cnt_q - gsdc_pkg::CNT_W'(1);
          end
        end
        ST_MSQ: begin
          m2_q    <= alu_rsp.prod[32:16];
          state_q <= ST_SCX;
        end
        ST_SCX: begin
          magx_q  <= alu_rsp.prod[32:16];
          state_q <= ST_SCY;
        end
        ST_SCY: begin
          magy_q  <= alu_rsp.prod[32:16];
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          ox_q    <= to_axis(magx_q, neg_x_q);
          oy_q    <= to_axis(magy_q, neg_y_q);
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.x    = ox_q;
  assign rsp_o.y    = oy_q;

endmodule

@@ rtl/core/gsdc_checker.sv @@
// ----------------------------------------------------------------------------
// gsdc_checker: port-level checks of the stick conditioner
// Watches the poll and result channels and flags slips in sequencing,
// saturation and activity reporting.
// ----------------------------------------------------------------------------
module gsdc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              poll_valid_i,
  input logic                              poll_ready_i,
  input logic                              res_valid_i,
  input logic                              res_ready_i,
  input logic signed [gsdc_pkg::AXIS_W-1:0] left_x_i,
  input logic signed [gsdc_pkg::AXIS_W-1:0] left_y_i,
  input logic signed [gsdc_pkg::AXIS_W-1:0] right_x_i,
  input logic signed [gsdc_pkg::AXIS_W-1:0] right_y_i,
  input logic [gsdc_pkg::BTN_W-1:0]         buttons_i,
  input logic                              activity_i
);

  localparam logic [gsdc_pkg::AXIS_W-1:0] AXIS_NEG_FULL = {1'b1, {(gsdc_pkg::AXIS_W-1){1'b0}}};

  // Hold a stalled result unchanged
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i &&
      $stable({left_x_i, left_y_i, right_x_i, right_y_i, buttons_i, activity_i}))
    else $error("stalled result changed");

  // One poll at a time: the sequencer leaves idle on every accepted request
  a_one_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    poll_valid_i && poll_ready_i |=> !poll_ready_i)
    else $error("poll taken while a previous poll is in flight");

  // No activity means every axis is at rest
  a_quiet_axes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !activity_i |->
      left_x_i == '0 && left_y_i == '0 && right_x_i == '0 && right_y_i == '0)
    else $error("axis moved without activity");

  // Axes stay within the symmetric range
  a_axis_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |->
      left_x_i != AXIS_NEG_FULL && left_y_i != AXIS_NEG_FULL &&
      right_x_i != AXIS_NEG_FULL && right_y_i != AXIS_NEG_FULL)
    else $error("axis not saturated");

endmodule

bind gamepad_stick_deadzone_curve gsdc_checker u_gsdc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .poll_valid_i (poll_i.valid),
  .poll_ready_i (poll_i.ready),
  .res_valid_i  (result_o.valid),
  .res_ready_i  (result_o.ready),
  .left_x_i     (result_o.left_x_out),
  .left_y_i     (result_o.left_y_out),
  .right_x_i    (result_o.right_x_out),
  .right_y_i    (result_o.right_y_out),
  .buttons_i    (result_o.buttons_out),
  .activity_i   (result_o.activity)
);

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the stick deadzone and response curve block
// Walks a short table of directed polls and then a long run of random polls
// over several register settings. A predictor in the bench works out every
// result; results are checked field by field in order of arrival, while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import gsdc_pkg::*;

  localparam int AXIS_LIMIT  = 32767;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 160;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 150;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [DZ_W-1:0] left_dz;
    logic [DZ_W-1:0] right_dz;
    logic            curve_on;
    logic            swap;
  } stick_cfg_t;

  typedef struct packed {
    logic                     pad;
    logic signed [AXIS_W-1:0] lx;
    logic signed [AXIS_W-1:0] ly;
    logic signed [AXIS_W-1:0] rx;
    logic signed [AXIS_W-1:0] ry;
    logic [BTN_W-1:0]         btn;
  } poll_req_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] lx;
    logic signed [AXIS_W-1:0] ly;
    logic signed [AXIS_W-1:0] rx;
    logic signed [AXIS_W-1:0] ry;
    logic [BTN_W-1:0]         btn;
    logic                     act;
  } stick_result_t;

  typedef struct packed {
    stick_cfg_t    cfg;
    poll_req_t     poll;
    logic          typed;
    stick_result_t res;
  } dir_row_t;

  // Register settings used by the directed rows and the first random phases
  localparam stick_cfg_t SET_RESET    = '{15'd0, 15'd0, 1'b1, 1'b0};
  localparam stick_cfg_t SET_WIDE     = '{15'd4000, 15'd20000, 1'b1, 1'b0};
  localparam stick_cfg_t SET_EDGE     = '{15'd32766, 15'd32767, 1'b1, 1'b0};
  localparam stick_cfg_t SET_SWAP     = '{15'd32767, 15'd0, 1'b1, 1'b1};
  localparam stick_cfg_t SET_DIG      = '{15'd1000, 15'd0, 1'b0, 1'b0};
  localparam stick_cfg_t SET_DIG_MAX  = '{15'd32767, 15'd32767, 1'b0, 1'b1};
  localparam stick_cfg_t SET_DIG_ZERO = '{15'd0, 15'd0, 1'b0, 1'b0};
  localparam stick_result_t UNTYPED   = '0;
  localparam int DIR_ROWS = 22;

  // Directed polls; rows with typed set carry a result read straight off the spec
  dir_row_t dir_rows [DIR_ROWS] = '{
    // no pad: everything zero, buttons unchanged from reset
    '{SET_RESET, '{1'b0, 16'sd32767, 16'sh8000, -16'sd1, 16'sd1, 17'h1FFFF}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 17'h00000, 1'b0}},
    '{SET_RESET, '{1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 17'h00000}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 17'h00000, 1'b0}},
    // full deflection with no deadzone comes out unchanged
    '{SET_RESET, '{1'b1, 16'sd32767, 16'sd0, 16'sd0, 16'sd0, 17'h00000}, 1'b1,
      '{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 17'h00000, 1'b1}},
    // most negative sample saturates
    '{SET_RESET, '{1'b1, 16'sh8000, 16'sd0, 16'sd0, 16'sh8000, 17'h00000}, 1'b1,
      '{-16'sd32767, 16'sd0, 16'sd0, -16'sd32767, 17'h00000, 1'b1}},
    // diagonal corners clamp the magnitude
    '{SET_RESET, '{1'b1, 16'sd32767, 16'sd32767, -16'sd32767, -16'sd32767, 17'h00000},
      1'b1, '{16'sd32767, 16'sd32767, -16'sd32767, -16'sd32767, 17'h00000, 1'b1}},
    // button change, then the same buttons again
    '{SET_RESET, '{1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 17'h1FFFF}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 17'h1FFFF, 1'b1}},
    '{SET_RESET, '{1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 17'h1FFFF}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 17'h1FFFF, 1'b0}},
    '{SET_RESET, '{1'b1, 16'sd12000, -16'sd9000, 16'sd300, 16'sd25000, 17'h0A5A5}, 1'b0,
      UNTYPED},
    '{SET_RESET, '{1'b1, 16'sd1, -16'sd1, 16'sd0, 16'sd0, 17'h0A5A5}, 1'b0, UNTYPED},
    // pad lost: buttons drop to zero, which counts as activity
    '{SET_RESET, '{1'b0, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 17'h01234}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 17'h00000, 1'b1}},
    '{SET_WIDE, '{1'b1, 16'sd5000, 16'sd5000, 16'sd14000, 16'sd14000, 17'h10001}, 1'b0,
      UNTYPED},
    // exactly on the deadzone and just past it
    '{SET_WIDE, '{1'b1, 16'sd4000, 16'sd0, 16'sd20001, 16'sd0, 17'h10001}, 1'b0,
      UNTYPED},
    // deadzone one below full scale, and one at full scale
    '{SET_EDGE, '{1'b1, 16'sd32767, 16'sd0, 16'sd32767, 16'sd32767, 17'h00000}, 1'b1,
      '{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 17'h00000, 1'b1}},
    '{SET_EDGE, '{1'b1, 16'sh8000, 16'sd0, 16'sh8000, 16'sh8000, 17'h00000}, 1'b1,
      '{-16'sd32767, 16'sd0, 16'sd0, 16'sd0, 17'h00000, 1'b1}},
    // swapped sticks keep the deadzones in place
    '{SET_SWAP, '{1'b1, 16'sd32767, 16'sd0, -16'sd32767, 16'sd0, 17'h00100}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd32767, 16'sd0, 17'h00100, 1'b1}},
    '{SET_SWAP, '{1'b1, 16'sd7000, -16'sd3000, 16'sd100, 16'sd200, 17'h00100}, 1'b0,
      UNTYPED},
    // digital mode either side of the threshold
    '{SET_DIG, '{1'b1, 16'sd1001, 16'sd1000, -16'sd1001, 16'sd0, 17'h1FFFF}, 1'b1,
      '{16'sd32767, 16'sd0, -16'sd32767, 16'sd0, 17'h1FFFF, 1'b1}},
    '{SET_DIG, '{1'b1, -16'sd1000, 16'sh8000, 16'sd1, -16'sd1, 17'h1FFFF}, 1'b1,
      '{16'sd0, -16'sd32767, 16'sd32767, -16'sd32767, 17'h1FFFF, 1'b1}},
    '{SET_DIG_MAX, '{1'b1, 16'sh8000, 16'sd32767, 16'sd32767, 16'sh8000, 17'h1FFFF},
      1'b1, '{16'sd0, -16'sd32767, -16'sd32767, 16'sd0, 17'h1FFFF, 1'b1}},
    '{SET_DIG_MAX, '{1'b0, 16'sd100, 16'sd100, 16'sd100, 16'sd100, 17'h0FFFF}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 17'h00000, 1'b1}},
    '{SET_DIG_MAX, '{1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 17'h00000}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 17'h00000, 1'b0}},
    '{SET_DIG_ZERO, '{1'b1, 16'sd0, 16'sd1, -16'sd1, 16'sd32767, 17'h15555}, 1'b1,
      '{16'sd0, 16'sd32767, -16'sd32767, 16'sd32767, 17'h15555, 1'b1}}
  };

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DZ_W-1:0]      cfg_data_i;

  gsdc_poll_if   poll_if ();
  gsdc_result_if res_if ();

  gamepad_stick_deadzone_curve DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .poll_i     (poll_if),
    .result_o   (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  stick_cfg_t       reg_shadow = SET_RESET;
  logic [BTN_W-1:0] last_buttons = '0;
  logic [BTN_W-1:0] last_sent_btn = '0;
  stick_result_t    expected_sticks [$];
  int n_errors = 0;
  int n_polls = 0;
  int n_results = 0;
  int n_active = 0;
  int n_settings = 0;
  int n_cycles = 0;
  int hold_offs_asked = 0;

  // Integer square root, one result bit per pass
  function automatic longint int_root(input longint v);
    longint res;
    longint probe;
    res = 0;
    probe = longint'(1) << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v = v - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // Scale one axis by the squared curve factor (Q16) and saturate
  function automatic longint shape_axis(input longint x, input longint m2);
    longint r;
    r = (((x < 0) ? -x : x) * m2) >> 16;
    if (x < 0) r = -r;
    if (r > AXIS_LIMIT) r = AXIS_LIMIT;
    if (r < -AXIS_LIMIT) r = -AXIS_LIMIT;
    return r;
  endfunction

  // Radial deadzone followed by the cubic curve on magnitude
  function automatic void curve_stick(input longint x, input longint y, input longint dz,
                                      output longint ox, output longint oy);
    longint s;
    longint mag;
    longint m;
    longint m2;
    ox = 0;
    oy = 0;
    s = x * x + y * y;
    if (dz >= AXIS_LIMIT || s <= dz * dz) return;
    mag = int_root(s << 16);
    if (mag > (longint'(AXIS_LIMIT) << 8)) mag = longint'(AXIS_LIMIT) << 8;
    if (mag <= (dz << 8)) return;
    m = ((mag - (dz << 8)) << 16) / ((AXIS_LIMIT - dz) << 8);
    m2 = (m * m) >> 16;
    ox = shape_axis(x, m2);
    oy = shape_axis(y, m2);
  endfunction

  function automatic longint snap_axis(input longint x, input longint dz);
    if (((x < 0) ? -x : x) > dz) return (x < 0) ? -AXIS_LIMIT : AXIS_LIMIT;
    return 0;
  endfunction

  // Work out the conditioned sticks for one poll and advance the button history
  function automatic stick_result_t condition_poll(input poll_req_t p);
    stick_result_t r;
    longint lx, ly, rx, ry, t;
    longint olx, oly, orx, ory;
    logic [BTN_W-1:0] btn;
    lx = longint'($signed(p.lx));
    ly = longint'($signed(p.ly));
    rx = longint'($signed(p.rx));
    ry = longint'($signed(p.ry));
    olx = 0;
    oly = 0;
    orx = 0;
    ory = 0;
    btn = '0;
    if (p.pad) begin
      btn = p.btn;
      if (reg_shadow.swap) begin
        t = lx; lx = rx; rx = t;
        t = ly; ly = ry; ry = t;
      end
      if (reg_shadow.curve_on) begin
        curve_stick(lx, ly, longint'(reg_shadow.left_dz), olx, oly);
        curve_stick(rx, ry, longint'(reg_shadow.right_dz), orx, ory);
      end else begin
        olx = snap_axis(lx, longint'(reg_shadow.left_dz));
        oly = snap_axis(ly, longint'(reg_shadow.left_dz));
        orx = snap_axis(rx, longint'(reg_shadow.right_dz));
        ory = snap_axis(ry, longint'(reg_shadow.right_dz));
      end
    end
    r.lx = 16'(olx);
    r.ly = 16'(oly);
    r.rx = 16'(orx);
    r.ry = 16'(ory);
    r.btn = btn;
    r.act = (olx != 0) || (oly != 0) || (orx != 0) || (ory != 0) || (btn != last_buttons);
    last_buttons = btn;
    return r;
  endfunction

  // Random axis sample, biased towards the deadzone edge and the extremes
  function automatic logic signed [AXIS_W-1:0] rand_axis(input logic [DZ_W-1:0] dz);
    logic [AXIS_W-1:0] raw;
    int v;
    raw = 16'($urandom());
    case ($urandom_range(0, 9))
      0, 1, 2: return $signed(raw);
      3: begin
        case ($urandom_range(0, 5))
          0: v = 32767;
          1: v = -32767;
          2: v = -32768;
          3: v = 0;
          4: v = 1;
          default: v = -1;
        endcase
        return 16'(v);
      end
      4, 5: v = int'(dz) + int'($urandom_range(0, 64)) - 32;
      6, 7: v = int'($urandom_range(0, int'(dz) + int'(dz) / 2 + 200));
      default: v = int'($urandom_range(0, 512));
    endcase
    if (v > 32767) v = 32767;
    if (raw[0]) v = -v;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic poll_req_t random_poll();
    poll_req_t p;
    logic [DZ_W-1:0] dz_l;
    logic [DZ_W-1:0] dz_r;
    // raw left meets the right deadzone when the sticks are swapped
    dz_l = reg_shadow.swap ? reg_shadow.right_dz : reg_shadow.left_dz;
    dz_r = reg_shadow.swap ? reg_shadow.left_dz : reg_shadow.right_dz;
    p.pad = ($urandom_range(0, 7) != 0);
    p.lx = rand_axis(dz_l);
    p.ly = rand_axis(dz_l);
    p.rx = rand_axis(dz_r);
    p.ry = rand_axis(dz_r);
    case ($urandom_range(0, 7))
      0, 1: p.btn = last_sent_btn;
      2: p.btn = '0;
      default: p.btn = 17'($urandom());
    endcase
    last_sent_btn = p.btn;
    return p;
  endfunction

  // Offer one poll request, hold it until taken, then queue its result
  task automatic offer_poll(input poll_req_t p, input logic typed, input stick_result_t res);
    stick_result_t want;
    poll_if.valid       <= 1'b1;
    poll_if.pad_present <= p.pad;
    poll_if.raw_left_x  <= p.lx;
    poll_if.raw_left_y  <= p.ly;
    poll_if.raw_right_x <= p.rx;
    poll_if.raw_right_y <= p.ry;
    poll_if.button_mask <= p.btn;
    do @(posedge clk_i); while (!poll_if.ready);
    want = condition_poll(p);
    expected_sticks.push_back(typed ? res : want);
    n_polls++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    poll_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_sticks.size() != 0);
  endtask

  // Write all four registers back to back; only called with the block idle
  task automatic write_settings(input stick_cfg_t c);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_LEFT_DZ;
    cfg_data_i <= c.left_dz;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_RIGHT_DZ;
    cfg_data_i <= c.right_dz;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_ANALOG;
    cfg_data_i <= DZ_W'(c.curve_on);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SWAP;
    cfg_data_i <= DZ_W'(c.swap);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    reg_shadow = c;
    n_settings++;
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    forever begin
      @(posedge clk_i);
      n_cycles++;
      if (n_cycles >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
                 expected_sticks.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // Result side: phases of steady, patchy and sparse ready, short stalls,
  // and a long hold-off whenever the stimulus asks for one
  initial begin
    int stall_left;
    int mode_left;
    int mode;
    int hold_offs_done;
    logic rdy;
    stall_left = 0;
    mode_left = 0;
    mode = 0;
    hold_offs_done = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (hold_offs_done != hold_offs_asked) begin
        hold_offs_done++;
        stall_left = LONG_HOLD - 1;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 300);
        end
        mode_left--;
        case (mode)
          0: rdy = 1'b1;
          1: rdy = ($urandom_range(0, 3) != 0);
          2: rdy = ($urandom_range(0, 3) == 0);
          default: begin
            rdy = 1'b1;
            if ($urandom_range(0, 40) == 0) stall_left = $urandom_range(1, 60);
          end
        endcase
      end
      res_if.ready <= rdy;
    end
  end

  // Compare each accepted result request with the oldest expectation
  always @(posedge clk_i) begin
    stick_result_t got;
    stick_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.lx  = res_if.left_x_out;
      got.ly  = res_if.left_y_out;
      got.rx  = res_if.right_x_out;
      got.ry  = res_if.right_y_out;
      got.btn = res_if.buttons_out;
      got.act = res_if.activity;
      if (expected_sticks.size() == 0) begin
        $error("result request with no poll outstanding");
        n_errors++;
      end else begin
        want = expected_sticks.pop_front();
        check_field("left_x_out", $signed(want.lx), $signed(got.lx));
        check_field("left_y_out", $signed(want.ly), $signed(got.ly));
        check_field("right_x_out", $signed(want.rx), $signed(got.rx));
        check_field("right_y_out", $signed(want.ry), $signed(got.ry));
        check_field("buttons_out", want.btn, got.btn);
        check_field("activity", want.act, got.act);
        n_results++;
        if (got.act) n_active++;
      end
    end
  end

  // Stimulus
  initial begin
    stick_cfg_t c;
    int burst_left;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_LEFT_DZ;
    cfg_data_i          = '0;
    poll_if.valid       = 1'b0;
    poll_if.pad_present = 1'b0;
    poll_if.raw_left_x  = '0;
    poll_if.raw_left_y  = '0;
    poll_if.raw_right_x = '0;
    poll_if.raw_right_y = '0;
    poll_if.button_mask = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; settle before every change of registers
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg != reg_shadow) begin
        drain_results();
        write_settings(dir_rows[i].cfg);
      end
      offer_poll(dir_rows[i].poll, dir_rows[i].typed, dir_rows[i].res);
    end

    // Random phases, each under its own register setting
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: c = SET_RESET;
        1: c = '{15'd32766, 15'd32767, 1'b1, 1'b1};
        2: c = SET_DIG_ZERO;
        3: c = SET_DIG_MAX;
        default: begin
          c.left_dz  = 15'($urandom_range(0, 16000));
          c.right_dz = (phase == 7) ? 15'($urandom_range(20000, 32767))
                                    : 15'($urandom_range(0, 16000));
          c.curve_on = (phase != 5);
          c.swap     = 1'($urandom_range(0, 1));
        end
      endcase
      drain_results();
      write_settings(c);
      burst_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold the result side off while polls keep coming
        if (n == 3 && (phase == 0 || phase == 4)) hold_offs_asked++;
        if (burst_left == 0) begin
          if ($urandom_range(0, 47) == 0) begin
            drain_results();
          end else begin
            poll_if.valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk_i);
          end
          burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        offer_poll(random_poll(), 1'b0, UNTYPED);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_sticks.size() != 0) begin
      $error("%0d results never arrived", expected_sticks.size());
      n_errors++;
    end
    $display("covered %0d polls over %0d register settings: curve and digital, swapped,",
             n_polls, n_settings);
    $display("deadzones from 0 to full scale; %0d results compared, %0d active, %0d errors",
             n_results, n_active, n_errors);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ gamepad_stick_deadzone_curve.f @@
rtl/core/gsdc_pkg.sv
rtl/core/gsdc_poll_if.sv
rtl/core/gsdc_result_if.sv
rtl/core/gsdc_alu.sv
rtl/core/gsdc_stick.sv
rtl/core/gamepad_stick_deadzone_curve.sv
rtl/core/gsdc_checker.sv
tb/sv/tb_top.sv
